// ----- rtl/core/tvq_pkg.sv -----
// tvq_pkg: shared constants, codes and item structs of the transmit virtqueue
// descriptor manager. Depends on nothing; every other file imports it.

package tvq_pkg;

   // default configuration of the descriptor ring
   localparam int RING_DEPTH_DEF   = 16;
   localparam int BUFFER_BYTES_DEF = 2048;

   // length prefix placed in front of every frame
   localparam int PREFIX_BYTES = 2;

   // field widths of the channel words
   localparam int FRAME_LEN_W  = 16;
   localparam int ID_W         = 4;
   localparam int STATUS_W     = 2;
   localparam int DESC_LEN_W   = 12;
   localparam int COUNT_W      = 16;
   localparam int FREE_COUNT_W = 5;

   // request action codes
   typedef enum logic {
      ACTION_SUBMIT   = 1'b0,
      ACTION_COMPLETE = 1'b1
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_SUBMITTED = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_FREE   = 2'd2,
      STATUS_COMPLETED = 2'd3
   } status_type;

   // request word as held in the input register
   typedef struct packed {
      action_type             action;
      logic [FRAME_LEN_W-1:0] frame_bytes;
      logic [ID_W-1:0]        completed_id;
   } req_item_type;

   // response word as held in the result register
   typedef struct packed {
      status_type              status;
      logic [ID_W-1:0]         desc_index;
      logic [DESC_LEN_W-1:0]   desc_len;
      logic [ID_W-1:0]         avail_slot;
      logic [COUNT_W-1:0]      avail_count;
      logic [FREE_COUNT_W-1:0] free_count;
      logic [COUNT_W-1:0]      used_count;
   } rsp_item_type;

   // free list commands from the engine
   typedef struct packed {
      logic pop;
      logic push;
   } fl_cmd_type;

   // free list status to the engine
   typedef struct packed {
      logic empty;
   } fl_stat_type;

endpackage

// ----- rtl/core/tvq_if.sv -----
// tvq_if: valid/ready channel interfaces for request and response words.
// Depends on tvq_pkg for field widths.

interface tvq_req_if;
   import tvq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [FRAME_LEN_W-1:0] frame_bytes;
   logic [ID_W-1:0]        completed_id;

   modport source(output valid, action, frame_bytes, completed_id, input ready);
   modport sink(input valid, action, frame_bytes, completed_id, output ready);
endinterface

interface tvq_rsp_if;
   import tvq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [ID_W-1:0]         desc_index;
   logic [DESC_LEN_W-1:0]   desc_len;
   logic [ID_W-1:0]         avail_slot;
   logic [COUNT_W-1:0]      avail_count;
   logic [FREE_COUNT_W-1:0] free_count;
   logic [COUNT_W-1:0]      used_count;

   modport source(output valid, status, desc_index, desc_len, avail_slot, avail_count,
                  free_count, used_count, input ready);
   modport sink(input valid, status, desc_index, desc_len, avail_slot, avail_count,
                free_count, used_count, output ready);
endinterface

// ----- rtl/core/tvq_in_reg.sv -----
// tvq_in_reg: input register of the request channel.
// Depends on tvq_pkg and tvq_req_if.

module tvq_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   tvq_req_if.sink              req_ch,
   input  logic                 advance,
   output logic                 in_valid,
   output tvq_pkg::req_item_type in_item
);
   import tvq_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         req_fire;

   // take a new word when empty or when the held word moves on
   assign req_ch.ready = !valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_fire) begin
         valid_in             = 1'b1;
         item_in.action       = action_type'(req_ch.action);
         item_in.frame_bytes  = req_ch.frame_bytes;
         item_in.completed_id = req_ch.completed_id;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign in_valid = valid_ff;
   assign in_item  = item_ff;
endmodule

// ----- rtl/core/tvq_free_list.sv -----
// tvq_free_list: linked free list of transmit descriptors with head and count.
// Depends on tvq_pkg for the command and status structs.

module tvq_free_list #(
   parameter int RING_DEPTH = tvq_pkg::RING_DEPTH_DEF,
   parameter int IDX_W      = $clog2(RING_DEPTH),
   parameter int LINK_W     = $clog2(RING_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tvq_pkg::fl_cmd_type  cmd,
   input  logic [IDX_W-1:0]     push_id,
   output tvq_pkg::fl_stat_type stat,
   output logic [LINK_W-1:0]    head,
   output logic [LINK_W-1:0]    total_next
);
   import tvq_pkg::*;

   localparam logic [LINK_W-1:0] LINK_END = LINK_W'(RING_DEPTH);

   logic [LINK_W-1:0] link_ff [RING_DEPTH];
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0]  head_idx;

   assign head_idx = head_ff[IDX_W-1:0];

   // empty when the count is zero or the head is the end marker
   assign stat.empty = (total_ff == '0) || (head_ff >= LINK_END);

   // next head and count
   always_comb begin
      head_in  = head_ff;
      total_in = total_ff;
      if (cmd.pop) begin
         head_in  = link_ff[head_idx];
         total_in = total_ff - 1'b1;
      end else if (cmd.push) begin
         head_in = LINK_W'(push_id);
         if (total_ff < LINK_END) begin
            total_in = total_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            link_ff[i] <= LINK_W'(i + 1);
         end
         head_ff  <= '0;
         total_ff <= LINK_END;
      end else begin
         if (cmd.push && !cmd.pop) begin
            link_ff[push_id] <= head_ff;
         end
         head_ff  <= head_in;
         total_ff <= total_in;
      end
   end

   assign head       = head_ff;
   assign total_next = total_in;

   // checks
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= LINK_END)
      else $error("free count above ring depth");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty)
      else $error("pop from empty free list");
   a_pop_push_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && cmd.push))
      else $error("pop and push in the same cycle");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> total_ff == $past(total_ff) - 1'b1)
      else $error("pop did not lower the free count");
endmodule

// ----- rtl/core/tvq_engine.sv -----
// tvq_engine: decides each request, drives the free list and keeps the ring counters.
// Depends on tvq_pkg; works with tvq_free_list.

module tvq_engine #(
   parameter int RING_DEPTH   = tvq_pkg::RING_DEPTH_DEF,
   parameter int BUFFER_BYTES = tvq_pkg::BUFFER_BYTES_DEF,
   parameter int IDX_W        = $clog2(RING_DEPTH),
   parameter int LINK_W       = $clog2(RING_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  tvq_pkg::req_item_type in_item,
   input  tvq_pkg::fl_stat_type  fl_stat,
   input  logic [LINK_W-1:0]     fl_head,
   input  logic [LINK_W-1:0]     fl_total_next,
   output tvq_pkg::fl_cmd_type   fl_cmd,
   output logic [IDX_W-1:0]      fl_push_id,
   output tvq_pkg::rsp_item_type rsp_item
);
   import tvq_pkg::*;

   localparam logic [FRAME_LEN_W:0]   MAX_FRAME   = (FRAME_LEN_W + 1)'(BUFFER_BYTES - PREFIX_BYTES);
   localparam logic [FRAME_LEN_W-1:0] PREFIX_LEN  = FRAME_LEN_W'(PREFIX_BYTES);
   localparam logic [IDX_W-1:0]       SLOT_LAST   = IDX_W'(RING_DEPTH - 1);
   localparam logic [ID_W:0]          ID_LIMIT    = (ID_W + 1)'(RING_DEPTH > 16 ? 16 : RING_DEPTH);

   logic [COUNT_W-1:0]     avail_ff, avail_in;
   logic [COUNT_W-1:0]     used_ff, used_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   is_submit, too_large, do_pop, id_ok;
   logic [FRAME_LEN_W-1:0] len_sum;

   // request decode
   assign is_submit = (in_item.action == ACTION_SUBMIT);
   assign too_large = {1'b0, in_item.frame_bytes} > MAX_FRAME;
   assign do_pop    = is_submit && !too_large && !fl_stat.empty;
   assign id_ok     = {1'b0, in_item.completed_id} < ID_LIMIT;
   assign len_sum   = in_item.frame_bytes + PREFIX_LEN;

   // free list commands, only when the word moves on
   assign fl_cmd.pop  = advance && do_pop;
   assign fl_cmd.push = advance && !is_submit && id_ok;
   assign fl_push_id  = IDX_W'(in_item.completed_id);

   // ring counters; slot tracks avail index modulo the ring depth
   always_comb begin
      avail_in = avail_ff;
      slot_in  = slot_ff;
      used_in  = used_ff;
      if (do_pop) begin
         avail_in = avail_ff + 1'b1;
         if (avail_ff == '1 || slot_ff == SLOT_LAST) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
      if (!is_submit) begin
         used_in = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         slot_ff  <= '0;
         used_ff  <= '0;
      end else if (advance) begin
         avail_ff <= avail_in;
         slot_ff  <= slot_in;
         used_ff  <= used_in;
      end
   end

   // response word
   always_comb begin
      rsp_item.desc_index  = '0;
      rsp_item.desc_len    = '0;
      rsp_item.avail_slot  = '0;
      rsp_item.avail_count = avail_in;
      rsp_item.free_count  = FREE_COUNT_W'(fl_total_next);
      rsp_item.used_count  = used_in;
      if (!is_submit) begin
         rsp_item.status     = STATUS_COMPLETED;
         rsp_item.desc_index = in_item.completed_id;
      end else if (too_large) begin
         rsp_item.status = STATUS_TOO_LARGE;
      end else if (fl_stat.empty) begin
         rsp_item.status = STATUS_NO_FREE;
      end else begin
         rsp_item.status     = STATUS_SUBMITTED;
         rsp_item.desc_index = ID_W'(fl_head);
         rsp_item.desc_len   = len_sum[DESC_LEN_W-1:0];
         rsp_item.avail_slot = ID_W'(slot_ff);
      end
   end
endmodule

// ----- rtl/core/tvq_out_reg.sv -----
// tvq_out_reg: result register of the response channel.
// Depends on tvq_pkg and tvq_rsp_if.

module tvq_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tvq_pkg::rsp_item_type rsp_item,
   output logic                  room,
   tvq_rsp_if.source             rsp_ch
);
   import tvq_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // a new word may enter when empty or when the held one is taken
   assign room = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = rsp_item;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.status      = item_ff.status;
   assign rsp_ch.desc_index  = item_ff.desc_index;
   assign rsp_ch.desc_len    = item_ff.desc_len;
   assign rsp_ch.avail_slot  = item_ff.avail_slot;
   assign rsp_ch.avail_count = item_ff.avail_count;
   assign rsp_ch.free_count  = item_ff.free_count;
   assign rsp_ch.used_count  = item_ff.used_count;
endmodule

// ----- rtl/core/tx_virtqueue_descriptor_manager.sv -----
// tx_virtqueue_descriptor_manager: driver-side transmit virtqueue descriptor manager.
// Depends on tvq_pkg, tvq_if, tvq_in_reg, tvq_free_list, tvq_engine and tvq_out_reg.
//
// Usage:
//   req_ch carries one word per submit (action 0, frame_len) or completion
//   (action 1, completed_id). rsp_ch returns exactly one word per request:
//   status, descriptor index, descriptor length, available ring slot and the
//   available, free and used counts after that request.
//   A request word is registered on acceptance and decided against the free
//   list and counters once the result register has room; its response is then
//   registered in the result register and offered. One word per cycle is
//   accepted and answered in steady state while rsp_ch is ready; the free list
//   pop/push and counter updates are registered together with the response word.
//   Reset rebuilds the free list (descriptor i links to i+1), makes all
//   descriptors free and clears the available and used counts.
//   When rsp_ch stalls, the result register holds its word and the input
//   register holds one more; req_ch.ready drops once both are full.

module tx_virtqueue_descriptor_manager #(
   parameter int RING_DEPTH   = tvq_pkg::RING_DEPTH_DEF,
   parameter int BUFFER_BYTES = tvq_pkg::BUFFER_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tvq_req_if.sink   req_ch,
   tvq_rsp_if.source rsp_ch
);
   import tvq_pkg::*;

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int LINK_W = $clog2(RING_DEPTH + 1);

   logic              in_valid, out_room, advance;
   req_item_type      in_item;
   rsp_item_type      rsp_item;
   fl_cmd_type        fl_cmd;
   fl_stat_type       fl_stat;
   logic [IDX_W-1:0]  fl_push_id;
   logic [LINK_W-1:0] fl_head, fl_total_next;

   // held word moves into the result register when there is room
   assign advance = in_valid && out_room;

   tvq_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .advance  (advance),
      .in_valid (in_valid),
      .in_item  (in_item)
   );

   tvq_free_list #(
      .RING_DEPTH (RING_DEPTH),
      .IDX_W      (IDX_W),
      .LINK_W     (LINK_W)
   ) u_free_list (
      .clock      (clock),
      .reset      (reset),
      .cmd        (fl_cmd),
      .push_id    (fl_push_id),
      .stat       (fl_stat),
      .head       (fl_head),
      .total_next (fl_total_next)
   );

   tvq_engine #(
      .RING_DEPTH   (RING_DEPTH),
      .BUFFER_BYTES (BUFFER_BYTES),
      .IDX_W        (IDX_W),
      .LINK_W       (LINK_W)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_item       (in_item),
      .fl_stat       (fl_stat),
      .fl_head       (fl_head),
      .fl_total_next (fl_total_next),
      .fl_cmd        (fl_cmd),
      .fl_push_id    (fl_push_id),
      .rsp_item      (rsp_item)
   );

   tvq_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .rsp_item (rsp_item),
      .room     (out_room),
      .rsp_ch   (rsp_ch)
   );
endmodule
